// ----- rtl/core/aabbct_pkg.sv -----
// Shared types, codes and the rectangle overlap test of the AABB collision table.
`default_nettype none
package aabbct_pkg;

  typedef enum logic [2:0] {
    CMD_ADD   = 3'd0,
    CMD_ERASE = 3'd1,
    CMD_EMAP  = 3'd2,
    CMD_MASK  = 3'd3,
    CMD_SCAN  = 3'd4,
    CMD_QUERY = 3'd5
  } cmd_e;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_FULL  = 2'd1;
  localparam logic [1:0] STAT_EMPTY = 2'd2;

  // one table entry as stored in the entry memory
  typedef struct packed {
    logic        listen;
    logic [3:0]  kind;
    logic [14:0] h;
    logic [14:0] w;
    logic [15:0] y;
    logic [15:0] x;
  } ent_t;

  // one result word
  typedef struct packed {
    logic [1:0] status;
    logic [2:0] aslot;
    logic       pv;
    logic [2:0] ns;
    logic [2:0] ps;
    logic       found;
    logic       last;
  } res_t;

  // touching edges count as overlap
  function automatic logic overlap(input ent_t a, input ent_t b);
    logic signed [17:0] ax, ay, bx, by, axr, ayb, bxr, byb;
    ax  = 18'($signed(a.x));
    ay  = 18'($signed(a.y));
    bx  = 18'($signed(b.x));
    by  = 18'($signed(b.y));
    axr = ax + $signed({3'b000, a.w});
    ayb = ay + $signed({3'b000, a.h});
    bxr = bx + $signed({3'b000, b.w});
    byb = by + $signed({3'b000, b.h});
    return !((bx > axr) || (bxr < ax) || (by > ayb) || (byb < ay));
  endfunction

endpackage
`default_nettype wire

// ----- rtl/core/aabb_collision_table.sv -----
// AABB collision table: entry and mask memories with a command sequencer.
//
// Broad-phase collision table of up to SLOTS typed rectangles plus a KINDS x KINDS
// interaction mask. One command word goes in on s_axis (cmd in tuser). Each command
// answers with result words on m_axis, and the final one carries tlast. Add, erase slot
// and write mask bit load their single result word at the accept edge, so it shows in
// the next cycle. A valid mask write then passes through ST_MW to read-modify-write
// its row. Erase map also answers at accept, then sweeps the entry memory slot by slot
// through ST_EMRD and ST_EMCK. Query sweeps the same way through ST_QYRD and ST_QYCK
// and answers from ST_QYFN once the output can take the word.
// Scan walks every pair i<k of valid slots through the entry memory read port:
//  - a skipped outer or partner slot passes through ST_SCI or ST_SCK
//  - an outer entry loads through ST_SCI, ST_SCIM and ST_SCIL
//  - a visited pair passes ST_SCK, ST_SCKM and ST_SCKL, then emits its words in ST_SCE1
//  - the final word leaves from ST_SCI
// Reads through that one port pace the walk, and output stalls lengthen it. The mask
// memory needs no clearing pass: a row-valid flop per row makes unwritten rows read as
// zero.
`default_nettype none
module aabb_collision_table #(
  parameter int SLOTS = 8,
  parameter int KINDS = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // pos_x[15:0] pos_y[31:16] width[46:32] height[61:47] kind[65:62] slot[68:66]
  // has_listener[69] other_kind[73:70] mask_value[74] match_any[75], zero pad
  input  wire logic [79:0] s_axis_tdata,
  input  wire logic [2:0]  s_axis_tuser,   // cmd[2:0]
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // status[1:0] assigned_slot[4:2] notified_slot[7:5] partner_slot[10:8]
  // found[11], zero pad
  output logic [15:0]      m_axis_tdata,
  output logic             m_axis_tuser,   // pair_valid
  output logic             m_axis_tlast,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [3:0]  cfg_data_i
);

  localparam int SW = $clog2(SLOTS);
  localparam int KW = $clog2(KINDS);
  localparam logic [SW-1:0] LAST_SLOT = SW'(SLOTS - 1);

  typedef enum logic [13:0] {
    ST_IDLE = 14'b00000000000001,
    ST_MW   = 14'b00000000000010,
    ST_EMRD = 14'b00000000000100,
    ST_EMCK = 14'b00000000001000,
    ST_QYRD = 14'b00000000010000,
    ST_QYCK = 14'b00000000100000,
    ST_QYFN = 14'b00000001000000,
    ST_SCI  = 14'b00000010000000,
    ST_SCIM = 14'b00000100000000,
    ST_SCIL = 14'b00001000000000,
    ST_SCK  = 14'b00010000000000,
    ST_SCKM = 14'b00100000000000,
    ST_SCKL = 14'b01000000000000,
    ST_SCE1 = 14'b10000000000000
  } state_e;
  // second emit and final word reuse extra flags rather than more states
  logic e2_q, e2_d, fin_q, fin_d;

  state_e state_q, state_d;

  // memories
  aabbct_pkg::ent_t ent_mem [SLOTS];
  logic [KINDS-1:0] mask_mem [KINDS];
  aabbct_pkg::ent_t ent_rd_q;
  logic [KINDS-1:0] mask_rd_q;
  logic             mrv_q;

  logic             ent_we;
  logic [SW-1:0]    ent_waddr, ent_raddr;
  aabbct_pkg::ent_t ent_wdata;
  logic             mask_we;
  logic [KW-1:0]    mask_waddr, mask_raddr;
  logic [KINDS-1:0] mask_wdata;

  // control state
  logic [SLOTS-1:0] valid_q, valid_d;
  logic [KINDS-1:0] mv_q, mv_d;          // mask row written since reset
  logic [3:0]       lim_cfg_q;
  logic             out_valid_q, out_valid_d;

  // payload
  aabbct_pkg::res_t res_q, res_d;
  logic [SW-1:0]    i_q, i_d, k_q, k_d;
  logic [3:0]       lim_q, lim_d;
  aabbct_pkg::ent_t q_q, q_d;            // query rectangle, or outer scan entry
  aabbct_pkg::ent_t ek_q, ek_d;
  logic             any_q, any_d, found_q, found_d;
  logic [KW-1:0]    mw_row_q, mw_row_d, mw_col_q, mw_col_d;
  logic             mw_val_q, mw_val_d;
  logic [KINDS-1:0] mi_q, mi_d;
  logic             p1_q, p1_d, p2_q, p2_d;

  // input fields
  logic [2:0]       in_cmd;
  aabbct_pkg::ent_t in_ent;
  logic [2:0]       in_slot;
  logic [3:0]       in_other;
  logic             in_mval, in_any;

  assign in_cmd          = s_axis_tuser;
  assign in_ent.x        = s_axis_tdata[15:0];
  assign in_ent.y        = s_axis_tdata[31:16];
  assign in_ent.w        = s_axis_tdata[46:32];
  assign in_ent.h        = s_axis_tdata[61:47];
  assign in_ent.kind     = s_axis_tdata[65:62];
  assign in_slot         = s_axis_tdata[68:66];
  assign in_ent.listen   = s_axis_tdata[69];
  assign in_other        = s_axis_tdata[73:70];
  assign in_mval         = s_axis_tdata[74];
  assign in_any          = s_axis_tdata[75];

  function automatic logic kind_ok(input logic [3:0] k);
    return {1'b0, k} < 5'(KINDS);
  endfunction

  logic             can_emit, s_hs;
  logic             free_any;
  logic [SW-1:0]    free_idx;
  logic [KINDS-1:0] mask_row;
  logic             emit_en;
  aabbct_pkg::res_t emit_res;

  assign can_emit      = !out_valid_q || m_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE) && can_emit;
  assign s_hs          = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;
  assign mask_row      = mrv_q ? mask_rd_q : '0;

  // lowest free slot
  always_comb begin
    free_any = 1'b0;
    free_idx = '0;
    for (int s = SLOTS - 1; s >= 0; s--) begin
      if (!valid_q[s]) begin
        free_any = 1'b1;
        free_idx = SW'(s);
      end
    end
  end

  always_comb begin
    state_d     = state_q;
    valid_d     = valid_q;
    mv_d        = mv_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    res_d       = res_q;
    i_d = i_q;  k_d = k_q;  lim_d = lim_q;
    q_d = q_q;  ek_d = ek_q;  any_d = any_q;  found_d = found_q;
    mw_row_d = mw_row_q;  mw_col_d = mw_col_q;  mw_val_d = mw_val_q;
    mi_d = mi_q;  p1_d = p1_q;  p2_d = p2_q;  e2_d = e2_q;  fin_d = fin_q;
    ent_we = 1'b0;  ent_waddr = free_idx;  ent_wdata = in_ent;  ent_raddr = i_q;
    mask_we = 1'b0;  mask_waddr = mw_row_q;  mask_wdata = '0;
    mask_raddr = in_ent.kind[KW-1:0];
    emit_en  = 1'b0;
    emit_res = '0;
    emit_res.last = 1'b1;

    unique case (state_q)
      ST_IDLE: begin
        if (s_hs) begin
          unique case (in_cmd)
            aabbct_pkg::CMD_ADD: begin
              emit_en = 1'b1;
              if (free_any) begin
                ent_we            = 1'b1;
                valid_d[free_idx] = 1'b1;
                emit_res.aslot    = 3'(free_idx);
              end else begin
                emit_res.status = aabbct_pkg::STAT_FULL;
              end
            end
            aabbct_pkg::CMD_ERASE: begin
              emit_en = 1'b1;
              if ({1'b0, in_slot} < 4'(SLOTS) && valid_q[in_slot[SW-1:0]]) begin
                valid_d[in_slot[SW-1:0]] = 1'b0;
              end else begin
                emit_res.status = aabbct_pkg::STAT_EMPTY;
              end
            end
            aabbct_pkg::CMD_EMAP: begin
              emit_en = 1'b1;
              lim_d   = lim_cfg_q;
              i_d     = '0;
              state_d = ST_EMRD;
            end
            aabbct_pkg::CMD_MASK: begin
              emit_en = 1'b1;
              if (kind_ok(in_ent.kind) && kind_ok(in_other)) begin
                mw_row_d = in_ent.kind[KW-1:0];
                mw_col_d = in_other[KW-1:0];
                mw_val_d = in_mval;
                state_d  = ST_MW;
              end
            end
            aabbct_pkg::CMD_SCAN: begin
              i_d     = '0;
              fin_d   = 1'b0;
              state_d = ST_SCI;
            end
            aabbct_pkg::CMD_QUERY: begin
              q_d     = in_ent;
              any_d   = in_any;
              found_d = 1'b0;
              i_d     = '0;
              state_d = ST_QYRD;
            end
            default: emit_en = 1'b1;
          endcase
        end
      end
      ST_MW: begin
        mask_we              = 1'b1;
        mask_wdata           = mask_row;
        mask_wdata[mw_col_q] = mw_val_q;
        mv_d[mw_row_q]       = 1'b1;
        state_d              = ST_IDLE;
      end
      ST_EMRD: state_d = ST_EMCK;
      ST_EMCK: begin
        if (ent_rd_q.kind <= lim_q) valid_d[i_q] = 1'b0;
        if (i_q == LAST_SLOT) begin
          state_d = ST_IDLE;
        end else begin
          i_d     = i_q + 1'b1;
          state_d = ST_EMRD;
        end
      end
      ST_QYRD: state_d = ST_QYCK;
      ST_QYCK: begin
        if (valid_q[i_q] && (any_q || ent_rd_q.kind == q_q.kind) &&
            aabbct_pkg::overlap(q_q, ent_rd_q)) begin
          found_d = 1'b1;
        end
        if (i_q == LAST_SLOT) begin
          state_d = ST_QYFN;
        end else begin
          i_d     = i_q + 1'b1;
          state_d = ST_QYRD;
        end
      end
      ST_QYFN: begin
        if (can_emit) begin
          emit_en        = 1'b1;
          emit_res.found = found_q;
          state_d        = ST_IDLE;
        end
      end
      // outer slot: skip empty ones, the final slot has no partner left
      ST_SCI: begin
        if (fin_q || i_q == LAST_SLOT) begin
          if (can_emit) begin
            emit_en = 1'b1;
            state_d = ST_IDLE;
          end
        end else if (valid_q[i_q]) begin
          state_d = ST_SCIM;
        end else begin
          i_d = i_q + 1'b1;
        end
      end
      ST_SCIM: begin
        q_d        = ent_rd_q;
        mask_raddr = ent_rd_q.kind[KW-1:0];
        k_d        = i_q + 1'b1;
        state_d    = ST_SCIL;
      end
      ST_SCIL: begin
        mi_d    = kind_ok(q_q.kind) ? mask_row : '0;
        state_d = ST_SCK;
      end
      ST_SCK: begin
        ent_raddr = k_q;
        if (valid_q[k_q]) begin
          state_d = ST_SCKM;
        end else if (k_q == LAST_SLOT) begin
          i_d     = i_q + 1'b1;
          state_d = ST_SCI;
        end else begin
          k_d = k_q + 1'b1;
        end
      end
      ST_SCKM: begin
        ek_d       = ent_rd_q;
        mask_raddr = ent_rd_q.kind[KW-1:0];
        state_d    = ST_SCKL;
      end
      ST_SCKL: begin
        p1_d = aabbct_pkg::overlap(q_q, ek_q) && kind_ok(ek_q.kind) &&
               mi_q[ek_q.kind[KW-1:0]] && q_q.listen;
        p2_d = aabbct_pkg::overlap(q_q, ek_q) && kind_ok(ek_q.kind) &&
               kind_ok(q_q.kind) && mask_row[q_q.kind[KW-1:0]] && ek_q.listen;
        e2_d    = 1'b0;
        state_d = ST_SCE1;
      end
      ST_SCE1: begin
        if (!e2_q) begin
          // pair (i,k)
          if (!p1_q) begin
            e2_d = 1'b1;
          end else if (can_emit) begin
            emit_en     = 1'b1;
            emit_res.pv = 1'b1;
            emit_res.ns = 3'(i_q);
            emit_res.ps = 3'(k_q);
            emit_res.last = 1'b0;
            e2_d        = 1'b1;
          end
        end else if (!p2_q || can_emit) begin
          // pair (k,i), then next partner
          if (p2_q) begin
            emit_en     = 1'b1;
            emit_res.pv = 1'b1;
            emit_res.ns = 3'(k_q);
            emit_res.ps = 3'(i_q);
            emit_res.last = 1'b0;
          end
          if (k_q == LAST_SLOT) begin
            i_d     = i_q + 1'b1;
            state_d = ST_SCI;
          end else begin
            k_d     = k_q + 1'b1;
            state_d = ST_SCK;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase

    if (state_q == ST_SCI || state_q == ST_EMRD || state_q == ST_QYRD) ent_raddr = i_q;

    if (emit_en) begin
      res_d       = emit_res;
      out_valid_d = 1'b1;
    end
  end

  // memories: one write and one registered read per cycle each
  always_ff @(posedge clk_i) begin
    if (ent_we) ent_mem[ent_waddr] <= ent_wdata;
    ent_rd_q <= ent_mem[ent_raddr];
    if (mask_we) mask_mem[mask_waddr] <= mask_wdata;
    mask_rd_q <= mask_mem[mask_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      valid_q     <= '0;
      mv_q        <= '0;
      mrv_q       <= 1'b0;
      lim_cfg_q   <= '0;
      out_valid_q <= 1'b0;
      e2_q        <= 1'b0;
      fin_q       <= 1'b0;
    end else begin
      state_q     <= state_d;
      valid_q     <= valid_d;
      mv_q        <= mv_d;
      mrv_q       <= mv_q[mask_raddr];
      out_valid_q <= out_valid_d;
      e2_q        <= e2_d;
      fin_q       <= fin_d;
      if (cfg_valid_i) lim_cfg_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q    <= res_d;
    i_q      <= i_d;
    k_q      <= k_d;
    lim_q    <= lim_d;
    q_q      <= q_d;
    ek_q     <= ek_d;
    any_q    <= any_d;
    found_q  <= found_d;
    mw_row_q <= mw_row_d;
    mw_col_q <= mw_col_d;
    mw_val_q <= mw_val_d;
    mi_q     <= mi_d;
    p1_q     <= p1_d;
    p2_q     <= p2_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'b0000, res_q.found, res_q.ps, res_q.ns, res_q.aslot,
                          res_q.status};
  assign m_axis_tuser  = res_q.pv;
  assign m_axis_tlast  = res_q.last;

  // a pair word never names one slot twice and never closes a command
  a_pair_distinct: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |-> (res_q.ns != res_q.ps) && !m_axis_tlast)
    else $error("bad pair word");

  a_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q))
    else $error("state not one-hot");

  // a new word is never loaded over one that is still held back
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !m_axis_tready) |=> $stable(res_q))
    else $error("result overwritten");

endmodule
`default_nettype wire
